[sv/wto_pkg.sv]
// ============================================================================
// wto_pkg
// Shared types, constants and waveform table for the wavetable oscillator.
// ============================================================================
package wto_pkg;

    localparam int PHASE_W   = 32;
    localparam int IDX_W     = 8;
    localparam int AMP_W     = 16;
    localparam int SAMPLE_W  = 16;
    localparam int DATA_W    = 32;
    localparam int ADDR_W    = 4;

    localparam int Q_DEPTH   = 2;
    localparam int QPTR_W    = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
    localparam int QCNT_W    = $clog2(Q_DEPTH + 1);

    localparam logic [1:0] REG_PHASE_INC = 2'd0;
    localparam logic [1:0] REG_WAVEFORM  = 2'd1;
    localparam logic [1:0] REG_AMPLITUDE = 2'd2;

    typedef enum logic [2:0] {
        WAVE_SINE,
        WAVE_TRIANGLE,
        WAVE_FALL,
        WAVE_RISE,
        WAVE_PULSE
    } wave_t;

    typedef struct packed {
        wave_t             waveform;
        logic [AMP_W-1:0]  amplitude;
    } cfg_t;

    typedef struct packed {
        logic              full;
        logic              empty;
        logic [QCNT_W-1:0] count;
    } q_stat_t;

    // floor(127*sin(k*pi/128)), k = 0..64
    localparam logic [7:0] QUARTER_SINE [0:64] = '{
        8'd0,   8'd3,   8'd6,   8'd9,   8'd12,  8'd15,  8'd18,  8'd21,
        8'd24,  8'd27,  8'd30,  8'd33,  8'd36,  8'd39,  8'd42,  8'd45,
        8'd48,  8'd51,  8'd54,  8'd57,  8'd59,  8'd62,  8'd65,  8'd67,
        8'd70,  8'd73,  8'd75,  8'd78,  8'd80,  8'd82,  8'd85,  8'd87,
        8'd89,  8'd91,  8'd94,  8'd96,  8'd98,  8'd100, 8'd102, 8'd103,
        8'd105, 8'd107, 8'd108, 8'd110, 8'd112, 8'd113, 8'd114, 8'd116,
        8'd117, 8'd118, 8'd119, 8'd120, 8'd121, 8'd122, 8'd123, 8'd123,
        8'd124, 8'd125, 8'd125, 8'd126, 8'd126, 8'd126, 8'd126, 8'd126,
        8'd127
    };

    function automatic logic [7:0] sine_byte(input logic [IDX_W-1:0] i);
        logic [6:0] j;
        logic [6:0] k;
        logic [7:0] q;
        logic [7:0] res;
        j = i[6:0];
        k = (j <= 7'd64) ? j : 7'(8'd128 - {1'b0, j});
        q = QUARTER_SINE[k];
        if (!i[7])
            res = 8'd127 + q;
        else if (k == 7'd0)
            res = 8'd127;
        else if (k == 7'd64)
            res = 8'd0;
        else
            res = 8'd126 - q;
        return res;
    endfunction

    function automatic logic [7:0] wave_byte(input wave_t wave,
                                             input logic [IDX_W-1:0] i);
        logic [7:0] res;
        case (wave)
            WAVE_TRIANGLE: res = i[7] ? {i[6:0], 1'b0} : 8'd255 - {i[6:0], 1'b0};
            WAVE_FALL:     res = ~i;
            WAVE_RISE:     res = i;
            WAVE_PULSE:    res = i[7] ? 8'd0 : 8'd255;
            default:       res = sine_byte(i);
        endcase
        return res;
    endfunction

endpackage

[sv/wto_front.sv]
// ============================================================================
// wto_front
// Phase accumulator: takes tick words, applies restart, queues table index.
// ============================================================================
module wto_front (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic                          restart,
    input  logic [wto_pkg::PHASE_W-1:0]   phase_inc,
    input  wto_pkg::q_stat_t              q_stat,
    output logic                          push,
    output logic [wto_pkg::IDX_W-1:0]     push_idx
);

    logic [wto_pkg::PHASE_W-1:0] phase_reg;
    logic [wto_pkg::PHASE_W-1:0] phase_cur;
    logic [wto_pkg::PHASE_W-1:0] phase_next;

    assign in_ready   = !q_stat.full;
    assign push       = in_valid && in_ready;
    assign phase_cur  = restart ? '0 : phase_reg;
    assign push_idx   = phase_cur[wto_pkg::PHASE_W-1 -: wto_pkg::IDX_W];
    assign phase_next = phase_cur + phase_inc;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            phase_reg <= '0;
        else if (push)
            phase_reg <= phase_next;
    end

endmodule

[sv/wto_queue.sv]
// ============================================================================
// wto_queue
// Short index queue between the phase front end and the sample back end.
// ============================================================================
module wto_queue (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          push,
    input  logic [wto_pkg::IDX_W-1:0]     push_idx,
    input  logic                          pop,
    output logic [wto_pkg::IDX_W-1:0]     pop_idx,
    output wto_pkg::q_stat_t              q_stat
);

    logic [wto_pkg::IDX_W-1:0]  mem_reg [wto_pkg::Q_DEPTH];
    logic [wto_pkg::QPTR_W-1:0] wr_ptr_reg;
    logic [wto_pkg::QPTR_W-1:0] rd_ptr_reg;
    logic [wto_pkg::QCNT_W-1:0] count_reg;
    logic [wto_pkg::QPTR_W-1:0] wr_ptr_next;
    logic [wto_pkg::QPTR_W-1:0] rd_ptr_next;

    localparam logic [wto_pkg::QPTR_W-1:0] PTR_LAST = wto_pkg::QPTR_W'(wto_pkg::Q_DEPTH - 1);
    localparam logic [wto_pkg::QCNT_W-1:0] CNT_FULL = wto_pkg::QCNT_W'(wto_pkg::Q_DEPTH);

    assign wr_ptr_next  = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
    assign rd_ptr_next  = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
    assign pop_idx      = mem_reg[rd_ptr_reg];
    assign q_stat.full  = (count_reg == CNT_FULL);
    assign q_stat.empty = (count_reg == '0);
    assign q_stat.count = count_reg;

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= push_idx;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_next;
            if (pop)
                rd_ptr_reg <= rd_ptr_next;
            if (push && !pop)
                count_reg <= count_reg + 1'b1;
            else if (pop && !push)
                count_reg <= count_reg - 1'b1;
        end
    end

endmodule

[sv/wto_back.sv]
// ============================================================================
// wto_back
// Sample pipeline: table lookup, gain multiply, shift and saturate.
// ============================================================================
module wto_back (
    input  logic                               clk,
    input  logic                               rst_n,
    input  wto_pkg::cfg_t                      cfg,
    input  wto_pkg::q_stat_t                   q_stat,
    input  logic [wto_pkg::IDX_W-1:0]          pop_idx,
    output logic                               pop,
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic signed [wto_pkg::SAMPLE_W-1:0] audio_out
);

    localparam int D_W    = 9;
    localparam int PROD_W = D_W + wto_pkg::AMP_W + 1;
    localparam int SH_W   = PROD_W - 7;

    logic                               v1_reg, v2_reg, v3_reg;
    logic                               rdy1, rdy2, rdy3;
    logic signed [D_W-1:0]              d_reg, d_next;
    logic signed [PROD_W-1:0]           prod_reg, prod_next;
    logic signed [wto_pkg::SAMPLE_W-1:0] audio_reg, audio_next;
    logic signed [wto_pkg::AMP_W:0]     amp_s;
    logic signed [SH_W-1:0]             sh;

    assign rdy3 = !v3_reg || out_ready;
    assign rdy2 = !v2_reg || rdy3;
    assign rdy1 = !v1_reg || rdy2;
    assign pop  = !q_stat.empty && rdy1;

    assign d_next    = $signed({1'b0, wto_pkg::wave_byte(cfg.waveform, pop_idx)}) - 9'sd127;
    assign amp_s     = $signed({1'b0, cfg.amplitude});
    assign prod_next = PROD_W'(d_reg) * PROD_W'(amp_s);
    assign sh        = SH_W'(prod_reg >>> 7);

    always_comb
    begin
        if (sh > SH_W'(32767))
            audio_next = 16'sh7FFF;
        else if (sh < -SH_W'(32768))
            audio_next = 16'sh8000;
        else
            audio_next = sh[wto_pkg::SAMPLE_W-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (pop)
            d_reg <= d_next;
        if (v1_reg && rdy2)
            prod_reg <= prod_next;
        if (v2_reg && rdy3)
            audio_reg <= audio_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            if (rdy1)
                v1_reg <= pop;
            if (rdy2)
                v2_reg <= v1_reg;
            if (rdy3)
                v3_reg <= v2_reg;
        end
    end

    assign out_valid = v3_reg;
    assign audio_out = audio_reg;

endmodule

[sv/wavetable_oscillator_top.sv]
// ============================================================================
// wavetable_oscillator_top
// DDS oscillator: phase accumulator front end, index queue, sample back end.
// ============================================================================
// An accepted tick's index passes the queue, then d_reg, prod_reg and audio_reg.
// Throughput: one sample per cycle when out_ready is high (single phase adder).
// Stalls on out_ready fill the 3-stage back end, then the 2-entry queue.
// Reset clears phase, config registers (sine, zero gain, zero step) and queue.
module wavetable_oscillator_top (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [wto_pkg::ADDR_W-1:0]          paddr,
    input  logic [wto_pkg::DATA_W-1:0]          pwdata,
    output logic [wto_pkg::DATA_W-1:0]          prdata,
    output logic                                pready,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic                                restart,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic signed [wto_pkg::SAMPLE_W-1:0] audio_out
);

    logic [wto_pkg::PHASE_W-1:0] phase_inc_reg;
    wto_pkg::wave_t              waveform_reg;
    logic [wto_pkg::AMP_W-1:0]   amplitude_reg;
    wto_pkg::cfg_t               cfg;
    wto_pkg::q_stat_t            q_stat;
    logic                        wr_en;
    logic [1:0]                  reg_sel;
    logic                        push, pop;
    logic [wto_pkg::IDX_W-1:0]   push_idx, pop_idx;

    assign pready  = 1'b1;
    assign reg_sel = paddr[3:2];
    assign wr_en   = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_inc_reg <= '0;
            waveform_reg  <= wto_pkg::WAVE_SINE;
            amplitude_reg <= '0;
        end
        else if (wr_en)
        begin
            unique case (reg_sel)
                wto_pkg::REG_PHASE_INC: phase_inc_reg <= pwdata;
                wto_pkg::REG_WAVEFORM:
                begin
                    if (pwdata <= wto_pkg::DATA_W'(wto_pkg::WAVE_PULSE))
                        waveform_reg <= wto_pkg::wave_t'(pwdata[2:0]);
                end
                wto_pkg::REG_AMPLITUDE: amplitude_reg <= pwdata[wto_pkg::AMP_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_sel)
            wto_pkg::REG_PHASE_INC: prdata = phase_inc_reg;
            wto_pkg::REG_WAVEFORM:  prdata = wto_pkg::DATA_W'(waveform_reg);
            wto_pkg::REG_AMPLITUDE: prdata = wto_pkg::DATA_W'(amplitude_reg);
            default:                prdata = '0;
        endcase
    end

    assign cfg.waveform  = waveform_reg;
    assign cfg.amplitude = amplitude_reg;

    wto_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .restart   (restart),
        .phase_inc (phase_inc_reg),
        .q_stat    (q_stat),
        .push      (push),
        .push_idx  (push_idx)
    );

    wto_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_idx (push_idx),
        .pop      (pop),
        .pop_idx  (pop_idx),
        .q_stat   (q_stat)
    );

    wto_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .q_stat    (q_stat),
        .pop_idx   (pop_idx),
        .pop       (pop),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .audio_out (audio_out)
    );

    a_q_bound: assert property (@(posedge clk) disable iff (!rst_n)
        q_stat.count <= wto_pkg::QCNT_W'(wto_pkg::Q_DEPTH))
        else $error("queue count above depth");

    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> q_stat.count != '0)
        else $error("pop from empty queue");

    a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
        (push && !pop) |=> q_stat.count == $past(q_stat.count) + 1'b1)
        else $error("queue count lost a push");

    a_wave_legal: assert property (@(posedge clk) disable iff (!rst_n)
        waveform_reg <= wto_pkg::WAVE_PULSE)
        else $error("illegal waveform latched");

endmodule

[tb/tb_top.sv]
`timescale 1ns / 100ps
// ============================================================================
// tb_top
// Self-checking bench for the wavetable oscillator. Tick words go in over a
// valid/ready channel, samples come back over another; an in-bench model of
// the phase accumulator, waveform bytes and gain stage predicts each sample.
// Registers are written over APB between phases while the block is idle.
// ============================================================================
module tb_top;

    localparam int REG_SPARE = 3;

    // floor(127*sin(k*pi/128)), k = 0..64
    localparam int SINE_QTR [0:64] = '{
        0, 3, 6, 9, 12, 15, 18, 21, 24, 27,
        30, 33, 36, 39, 42, 45, 48, 51, 54, 57,
        59, 62, 65, 67, 70, 73, 75, 78, 80, 82,
        85, 87, 89, 91, 94, 96, 98, 100, 102, 103,
        105, 107, 108, 110, 112, 113, 114, 116, 117, 118,
        119, 120, 121, 122, 123, 123, 124, 125, 125, 126,
        126, 126, 126, 126, 127
    };

    logic                                clk = 1'b0;
    logic                                rst_n = 1'b0;
    logic                                psel = 1'b0;
    logic                                penable = 1'b0;
    logic                                pwrite = 1'b0;
    logic [wto_pkg::ADDR_W-1:0]          paddr = '0;
    logic [wto_pkg::DATA_W-1:0]          pwdata = '0;
    logic [wto_pkg::DATA_W-1:0]          prdata;
    logic                                pready;
    logic                                in_valid = 1'b0;
    logic                                in_ready;
    logic                                restart = 1'b0;
    logic                                out_valid;
    logic                                out_ready = 1'b0;
    logic signed [wto_pkg::SAMPLE_W-1:0] audio_out;

    // oscillator model state
    logic [wto_pkg::PHASE_W-1:0] osc_phase = '0;
    logic [wto_pkg::PHASE_W-1:0] osc_step = '0;
    wto_pkg::wave_t              osc_wave = wto_pkg::WAVE_SINE;
    logic [wto_pkg::AMP_W-1:0]   osc_gain = '0;

    logic                                tick_q[$];
    logic signed [wto_pkg::SAMPLE_W-1:0] sample_q[$];

    logic in_taken = 1'b0;
    bit   quiet = 1'b0;
    int   tx_gap = 0;
    int   rx_gap = 0;
    int   hold_cycles = 0;
    int   ticks_sent = 0;
    int   samples_seen = 0;
    int   cfg_writes = 0;
    int   err_count = 0;

    wavetable_oscillator_top uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .restart   (restart),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .audio_out (audio_out)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    function automatic int wave_level(input wto_pkg::wave_t w, input logic [7:0] i);
        int n;
        int k;
        n = int'(i);
        k = (n % 128 <= 64) ? n % 128 : 128 - n % 128;
        case (w)
            wto_pkg::WAVE_TRIANGLE: return (n < 128) ? 255 - 2 * n : 2 * (n - 128);
            wto_pkg::WAVE_FALL:     return 255 - n;
            wto_pkg::WAVE_RISE:     return n;
            wto_pkg::WAVE_PULSE:    return (n < 128) ? 255 : 0;
            default:
            begin
                if (n < 128)
                    return 127 + SINE_QTR[k];
                if (k == 0)
                    return 127;
                if (k == 64)
                    return 0;
                return 126 - SINE_QTR[k];
            end
        endcase
    endfunction

    // one tick: optional phase clear, sample from current phase, then advance
    function automatic logic signed [wto_pkg::SAMPLE_W-1:0] next_sample(input logic clear);
        int level;
        int prod;
        int r;
        if (clear)
            osc_phase = '0;
        level = wave_level(osc_wave,
                           osc_phase[wto_pkg::PHASE_W-1 -: wto_pkg::IDX_W]) - 127;
        prod = level * int'(osc_gain);
        r = prod >>> 7;
        if (r > 32767)
            r = 32767;
        if (r < -32768)
            r = -32768;
        osc_phase = osc_phase + osc_step;
        return r[wto_pkg::SAMPLE_W-1:0];
    endfunction

    task automatic report_mismatch(input string msg);
        $display("[%0t] ERROR: %s", $time, msg);
        err_count++;
    endtask

    task automatic write_reg(input int idx, input logic [wto_pkg::DATA_W-1:0] value);
        @(negedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= wto_pkg::ADDR_W'(idx * 4);
        pwdata <= value;
        @(negedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        case (idx)
            wto_pkg::REG_PHASE_INC: osc_step = value;
            wto_pkg::REG_WAVEFORM:
            begin
                if (value <= wto_pkg::DATA_W'(wto_pkg::WAVE_PULSE))
                    osc_wave = wto_pkg::wave_t'(value[2:0]);
            end
            wto_pkg::REG_AMPLITUDE: osc_gain = value[wto_pkg::AMP_W-1:0];
            default: ;
        endcase
        cfg_writes++;
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    // wait until every word is in and every sample is back, plus pipeline slack
    task automatic settle();
        while (tick_q.size() != 0 || sample_q.size() != 0)
            @(posedge clk);
        repeat (6) @(posedge clk);
    endtask

    task automatic push_ticks(input int n, input int restart_odds);
        repeat (n)
            tick_q.push_back($urandom_range(0, restart_odds - 1) == 0);
    endtask

    // sender
    always @(negedge clk)
    begin
        if (!rst_n)
            in_valid <= 1'b0;
        else if (in_valid && !in_taken)
            ;
        else if (tx_gap > 0)
        begin
            in_valid <= 1'b0;
            tx_gap = tx_gap - 1;
        end
        else if (tick_q.size() == 0)
            in_valid <= 1'b0;
        else if (!quiet && $urandom_range(0, 7) == 0)
        begin
            in_valid <= 1'b0;
            tx_gap = $urandom_range(0, 4);
        end
        else
        begin
            in_valid <= 1'b1;
            restart <= tick_q[0];
        end
    end

    // receiver
    always @(negedge clk)
    begin
        if (!rst_n)
            out_ready <= 1'b0;
        else if (hold_cycles > 0)
        begin
            out_ready <= 1'b0;
            hold_cycles = hold_cycles - 1;
        end
        else if (rx_gap > 0)
        begin
            out_ready <= 1'b0;
            rx_gap = rx_gap - 1;
        end
        else if (!quiet && $urandom_range(0, 7) == 0)
        begin
            out_ready <= 1'b0;
            rx_gap = $urandom_range(0, 4);
        end
        else
            out_ready <= 1'b1;
    end

    // monitor and checker
    always @(posedge clk)
    begin
        logic signed [wto_pkg::SAMPLE_W-1:0] want;
        in_taken <= in_valid && in_ready;
        if (rst_n)
        begin
            if (in_valid && in_ready)
            begin
                sample_q.push_back(next_sample(restart));
                void'(tick_q.pop_front());
                ticks_sent++;
            end
            if (out_valid && out_ready)
            begin
                samples_seen++;
                if (sample_q.size() == 0)
                    report_mismatch($sformatf("unexpected sample %0d", audio_out));
                else
                begin
                    want = sample_q.pop_front();
                    if (audio_out !== want)
                        report_mismatch($sformatf("sample %0d: audio_out %0d, expected %0d",
                                                  samples_seen, audio_out, want));
                end
            end
        end
    end

    initial
    begin
        #2_000_000;
        $display("Simulation FAILED");
        $finish;
    end

    initial
    begin
        logic [wto_pkg::DATA_W-1:0] step;
        logic [wto_pkg::DATA_W-1:0] gain;
        int                         base;

        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // reset config: sine, zero gain, zero step
        tick_q.push_back(1'b0);
        tick_q.push_back(1'b1);
        settle();

        // spare address must not disturb anything; wrap with all-ones step
        write_reg(REG_SPARE, 32'hFFFF_FFFF);
        write_reg(wto_pkg::REG_PHASE_INC, 32'hFFFF_FFFF);
        write_reg(wto_pkg::REG_AMPLITUDE, 32'd32768);
        tick_q.push_back(1'b0);
        tick_q.push_back(1'b0);
        tick_q.push_back(1'b0);
        settle();

        // quarter-turn steps hit indexes 0, 64, 128, 192
        write_reg(wto_pkg::REG_PHASE_INC, 32'h4000_0000);
        write_reg(wto_pkg::REG_AMPLITUDE, 32'd65535);
        write_reg(wto_pkg::REG_WAVEFORM, 32'(wto_pkg::WAVE_TRIANGLE));
        tick_q.push_back(1'b1);
        repeat (3) tick_q.push_back(1'b0);
        settle();
        write_reg(wto_pkg::REG_WAVEFORM, 32'(wto_pkg::WAVE_PULSE));
        tick_q.push_back(1'b1);
        tick_q.push_back(1'b0);
        tick_q.push_back(1'b0);
        settle();
        write_reg(wto_pkg::REG_WAVEFORM, 32'(wto_pkg::WAVE_FALL));
        write_reg(wto_pkg::REG_AMPLITUDE, 32'd1);
        tick_q.push_back(1'b0);
        tick_q.push_back(1'b0);
        settle();
        write_reg(wto_pkg::REG_WAVEFORM, 32'(wto_pkg::WAVE_RISE));
        tick_q.push_back(1'b1);
        tick_q.push_back(1'b0);
        settle();
        // unknown codes are dropped, rising ramp stays selected
        write_reg(wto_pkg::REG_WAVEFORM, 32'd7);
        write_reg(wto_pkg::REG_WAVEFORM, 32'd5);
        write_reg(wto_pkg::REG_PHASE_INC, 32'd0);
        write_reg(wto_pkg::REG_AMPLITUDE, 32'd32768);
        tick_q.push_back(1'b0);
        tick_q.push_back(1'b1);
        settle();
        write_reg(wto_pkg::REG_WAVEFORM, 32'(wto_pkg::WAVE_SINE));
        write_reg(wto_pkg::REG_PHASE_INC, 32'h0200_0000);
        tick_q.push_back(1'b1);
        repeat (3) tick_q.push_back(1'b0);
        settle();

        for (int ph = 0; ph < 14; ph++)
        begin
            settle();
            quiet = (ph % 4 == 3) || (ph >= 12);
            if (ph == 0 || $urandom_range(0, 3) != 0)
            begin
                case ($urandom_range(0, 5))
                    0: step = 32'h0100_0000 * $urandom_range(1, 4);
                    1: step = $urandom;
                    2: step = ($urandom_range(0, 1) == 0) ? 32'hFFFF_FFFF : 32'd0;
                    3: step = $urandom_range(1, 32'h00FF_FFFF);
                    default: step = $urandom & 32'h0FFF_FFFF;
                endcase
                write_reg(wto_pkg::REG_PHASE_INC, step);
            end
            if (ph == 0 || $urandom_range(0, 3) != 0)
                write_reg(wto_pkg::REG_WAVEFORM, $urandom_range(0, 7));
            if (ph == 0 || $urandom_range(0, 3) != 0)
            begin
                case ($urandom_range(0, 5))
                    0: gain = 32'd0;
                    1: gain = 32'd32768;
                    2: gain = 32'd65535;
                    3: gain = 32'd1;
                    4: gain = $urandom_range(0, 32768);
                    default: gain = $urandom & 32'hFFFF;
                endcase
                write_reg(wto_pkg::REG_AMPLITUDE, gain);
            end
            if ($urandom_range(0, 4) == 0)
                write_reg(REG_SPARE, $urandom);

            if (ph == 6)
            begin
                // stall the sample side long enough to back up into the input
                base = ticks_sent;
                push_ticks(200, 16);
                while (ticks_sent < base + 10)
                    @(posedge clk);
                hold_cycles = 120;
            end
            else
                push_ticks(120, 16);
        end

        settle();
        repeat (10) @(posedge clk);
        $display("Covered %0d tick words, %0d samples, %0d register writes.",
                 ticks_sent, samples_seen, cfg_writes);
        $display("All five waveforms, unknown codes, gain 0..65535, restarts and phase wrap.");
        if (err_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
